@@ hdl/bmm_pkg.sv @@
`default_nettype none
package bmm_pkg;

  localparam int SEGMENTS          = 4;
  localparam int PAGES_PER_SEGMENT = 16;
  localparam int MAP_DEPTH         = SEGMENTS * PAGES_PER_SEGMENT;
  localparam int MAP_IDX_W         = $clog2(MAP_DEPTH);
  localparam int ENTRY_W           = 6;

  localparam logic [15:0] RESIDENT_BASE = 16'hfc00;
  localparam logic [15:0] WIN_LO        = 16'h7c00;
  localparam logic [15:0] WIN_HI        = 16'h7fff;
  localparam logic [15:0] ADDR_BOOT     = 16'hfd0b;
  localparam logic [15:0] ADDR_INITROM  = 16'hfd10;
  localparam logic [15:0] ADDR_MAP_BASE = 16'hfd80;
  localparam logic [15:0] ADDR_SEG      = 16'hfd90;
  localparam logic [15:0] ADDR_WOFF     = 16'hfd92;
  localparam logic [15:0] ADDR_MODE     = 16'hfd93;

  localparam logic [7:0] BYTE_ONES    = 8'hff;
  localparam logic [7:0] STATUS_BASIC = 8'hfe;

  localparam logic CFG_PRESENT = 1'b0;
  localparam logic CFG_BASIC   = 1'b1;

  typedef enum logic [2:0] {
    RGN_UNHANDLED = 3'd0,
    RGN_EXT_RAM   = 3'd1,
    RGN_SUBSYS    = 3'd2,
    RGN_RESERVED  = 3'd3,
    RGN_MAIN      = 3'd4,
    RGN_CTRL      = 3'd5
  } region_t;

  typedef struct packed {
    logic                 en;
    logic                 we;
    logic [MAP_IDX_W-1:0] idx;
    logic [ENTRY_W-1:0]   wdata;
  } ram_req_t;

  typedef struct packed {
    region_t     region;
    logic [15:0] target;
    logic [7:0]  rd;
    logic        wr;
    logic        xlate;
    logic        map_read;
    logic        initrom;
    logic        bootram;
  } stage_t;

endpackage
`default_nettype wire

@@ hdl/bmm_in_if.sv @@
`default_nettype none
interface bmm_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] bus_addr;
  logic [7:0]  write_data;

  modport source (output valid, output cmd, output bus_addr, output write_data, input ready);
  modport sink (input valid, input cmd, input bus_addr, input write_data, output ready);
endinterface
`default_nettype wire

@@ hdl/bmm_out_if.sv @@
`default_nettype none
interface bmm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  region;
  logic [15:0] target_addr;
  logic [7:0]  read_data;
  logic        initrom_enable;
  logic        bootram_writable;

  modport source (output valid, output region, output target_addr, output read_data,
                  output initrom_enable, output bootram_writable, input ready);
  modport sink (input valid, input region, input target_addr, input read_data,
                input initrom_enable, input bootram_writable, output ready);
endinterface
`default_nettype wire

@@ hdl/bmm_cfg_if.sv @@
`default_nettype none
interface bmm_cfg_if;
  logic valid;
  logic ready;
  logic addr;
  logic data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/bmm_map_ram.sv @@
`default_nettype none
module bmm_map_ram (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire bmm_pkg::ram_req_t                   req,
  output logic       [bmm_pkg::ENTRY_W-1:0]        entry
);

  logic [bmm_pkg::ENTRY_W-1:0] mem [bmm_pkg::MAP_DEPTH];
  logic [bmm_pkg::MAP_DEPTH-1:0] valid_r;
  logic [bmm_pkg::ENTRY_W-1:0] rdata_r;
  logic                        rvalid_r;

  always_ff @(posedge clk) begin
    if (req.en && req.we) begin
      mem[req.idx] <= req.wdata;
    end
    if (req.en && !req.we) begin
      rdata_r <= mem[req.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (req.en && req.we) begin
        valid_r[req.idx] <= 1'b1;
      end
      if (req.en && !req.we) begin
        rvalid_r <= valid_r[req.idx];
      end
    end
  end

  assign entry = rvalid_r ? rdata_r : '0;

endmodule
`default_nettype wire

@@ hdl/bmm_decode.sv @@
`default_nettype none
module bmm_decode (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_addr,
  input  wire logic               cfg_data,
  input  wire logic               acc,
  input  wire logic               cmd,
  input  wire logic [15:0]        bus_addr,
  input  wire logic [7:0]         write_data,
  output bmm_pkg::ram_req_t       ram_req,
  output bmm_pkg::stage_t         stage
);

  logic       present_r;
  logic       basic_r;
  logic [1:0] seg_r, seg_nxt;
  logic [7:0] woff_r, woff_nxt;
  logic       map_en_r, map_en_nxt;
  logic       win_en_r, win_en_nxt;
  logic       boot_rw_r, boot_rw_nxt;
  logic       init_rom_r, init_rom_nxt;
  logic [1:0] seg_eff;
  logic [3:0] page;
  logic [5:0] idx_full;
  logic       ram_en;
  logic       ram_we;

  always_comb begin
    seg_eff = (32'(seg_r) < bmm_pkg::SEGMENTS) ? seg_r : 2'd0;
  end

  always_comb begin
    seg_nxt      = seg_r;
    woff_nxt     = woff_r;
    map_en_nxt   = map_en_r;
    win_en_nxt   = win_en_r;
    boot_rw_nxt  = boot_rw_r;
    init_rom_nxt = init_rom_r;
    page         = bus_addr[15:12];
    ram_en       = 1'b0;
    ram_we       = 1'b0;
    stage.region   = bmm_pkg::RGN_UNHANDLED;
    stage.target   = bus_addr;
    stage.rd       = 8'h00;
    stage.wr       = cmd;
    stage.xlate    = 1'b0;
    stage.map_read = 1'b0;
    if (present_r) begin
      if (bus_addr >= bmm_pkg::RESIDENT_BASE) begin
        unique case (bus_addr)
          bmm_pkg::ADDR_BOOT: begin
            stage.region = bmm_pkg::RGN_CTRL;
            if (!cmd) stage.rd = basic_r ? bmm_pkg::STATUS_BASIC : bmm_pkg::BYTE_ONES;
          end
          bmm_pkg::ADDR_INITROM: begin
            stage.region = bmm_pkg::RGN_CTRL;
            if (cmd) init_rom_nxt = ~write_data[1];
            else stage.rd = bmm_pkg::BYTE_ONES;
          end
          bmm_pkg::ADDR_SEG: begin
            stage.region = bmm_pkg::RGN_CTRL;
            if (cmd) seg_nxt = write_data[1:0];
            else stage.rd = bmm_pkg::BYTE_ONES;
          end
          bmm_pkg::ADDR_WOFF: begin
            stage.region = bmm_pkg::RGN_CTRL;
            if (cmd) woff_nxt = write_data;
            else stage.rd = bmm_pkg::BYTE_ONES;
          end
          bmm_pkg::ADDR_MODE: begin
            stage.region = bmm_pkg::RGN_CTRL;
            if (cmd) begin
              map_en_nxt  = write_data[7];
              win_en_nxt  = write_data[6];
              boot_rw_nxt = write_data[0];
            end else begin
              stage.rd = {map_en_r, win_en_r, 5'h1f, boot_rw_r};
            end
          end
          default: begin
            if (bus_addr[15:4] == bmm_pkg::ADDR_MAP_BASE[15:4]) begin
              stage.region   = bmm_pkg::RGN_CTRL;
              page           = bus_addr[3:0];
              ram_en         = 1'b1;
              ram_we         = cmd;
              stage.map_read = !cmd;
            end
          end
        endcase
      end else if (win_en_r && bus_addr >= bmm_pkg::WIN_LO && bus_addr <= bmm_pkg::WIN_HI) begin
        stage.region = bmm_pkg::RGN_EXT_RAM;
        stage.target = {woff_r, 8'h00} + bus_addr;
      end else if (!map_en_r) begin
        stage.region = bmm_pkg::RGN_MAIN;
      end else begin
        ram_en      = 1'b1;
        stage.xlate = 1'b1;
      end
    end
    stage.initrom = init_rom_nxt;
    stage.bootram = boot_rw_nxt;
  end

  assign idx_full      = {seg_eff, page};
  assign ram_req.en    = acc && ram_en;
  assign ram_req.we    = ram_we;
  assign ram_req.idx   = idx_full[bmm_pkg::MAP_IDX_W-1:0];
  assign ram_req.wdata = write_data[bmm_pkg::ENTRY_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r  <= 1'b1;
      basic_r    <= 1'b1;
      seg_r      <= 2'd0;
      woff_r     <= 8'h00;
      map_en_r   <= 1'b0;
      win_en_r   <= 1'b0;
      boot_rw_r  <= 1'b0;
      init_rom_r <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          bmm_pkg::CFG_PRESENT: present_r <= cfg_data;
          bmm_pkg::CFG_BASIC:   basic_r   <= cfg_data;
          default: ;
        endcase
      end
      if (acc) begin
        seg_r      <= seg_nxt;
        woff_r     <= woff_nxt;
        map_en_r   <= map_en_nxt;
        win_en_r   <= win_en_nxt;
        boot_rw_r  <= boot_rw_nxt;
        init_rom_r <= init_rom_nxt;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/banked_memory_mapper_top.sv @@
`default_nettype none
// Banked memory mapper. Each bus access item is decoded in the cycle it is
// accepted: control registers update at once and the 64-entry page map RAM
// is read or written through its single port. The next cycle the registered
// map entry resolves region and target, and the result moves to the output
// register once that register is empty or being drained. One item is accepted
// every cycle while the output drains, so throughput is one item per clock,
// set by the one access per cycle of the map RAM port.
module banked_memory_mapper_top (
  input wire logic  clk,
  input wire logic  rst_n,
  bmm_in_if.sink    in_bus,
  bmm_out_if.source out_res,
  bmm_cfg_if.sink   cfg_bus
);

  bmm_pkg::ram_req_t ram_req;
  bmm_pkg::stage_t   stage;
  bmm_pkg::stage_t   s1_r;
  logic              s1_v_r;
  logic              out_v_r;
  logic [bmm_pkg::ENTRY_W-1:0] entry;
  logic              acc;
  logic              adv1;
  logic              in_ready;
  bmm_pkg::region_t  res_region;
  logic [15:0]       res_target;
  logic [7:0]        res_rd;
  bmm_pkg::region_t  out_region_r;
  logic [15:0]       out_target_r;
  logic [7:0]        out_rd_r;
  logic              out_initrom_r;
  logic              out_bootram_r;

  assign adv1     = s1_v_r && (!out_v_r || out_res.ready);
  assign in_ready = !s1_v_r || adv1;
  assign acc      = in_bus.valid && in_ready;
  assign in_bus.ready  = in_ready;
  assign cfg_bus.ready = 1'b1;

  bmm_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_bus.valid),
    .cfg_addr   (cfg_bus.addr),
    .cfg_data   (cfg_bus.data),
    .acc        (acc),
    .cmd        (in_bus.cmd),
    .bus_addr   (in_bus.bus_addr),
    .write_data (in_bus.write_data),
    .ram_req    (ram_req),
    .stage      (stage)
  );

  bmm_map_ram u_map_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ram_req),
    .entry (entry)
  );

  always_comb begin
    res_region = s1_r.region;
    res_target = s1_r.target;
    res_rd     = s1_r.rd;
    if (s1_r.xlate) begin
      case (entry[5:4])
        2'd0:    res_region = bmm_pkg::RGN_EXT_RAM;
        2'd1:    res_region = bmm_pkg::RGN_SUBSYS;
        2'd2:    res_region = bmm_pkg::RGN_RESERVED;
        default: res_region = bmm_pkg::RGN_MAIN;
      endcase
      res_target = {entry[3:0], s1_r.target[11:0]};
      res_rd     = (res_region == bmm_pkg::RGN_RESERVED && !s1_r.wr) ?
                   bmm_pkg::BYTE_ONES : 8'h00;
    end else if (s1_r.map_read) begin
      res_rd = {2'b00, entry};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) s1_v_r <= in_bus.valid;
      if (adv1) out_v_r <= 1'b1;
      else if (out_res.ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) s1_r <= stage;
    if (adv1) begin
      out_region_r  <= res_region;
      out_target_r  <= res_target;
      out_rd_r      <= res_rd;
      out_initrom_r <= s1_r.initrom;
      out_bootram_r <= s1_r.bootram;
    end
  end

  assign out_res.valid            = out_v_r;
  assign out_res.region           = out_region_r;
  assign out_res.target_addr      = out_target_r;
  assign out_res.read_data        = out_rd_r;
  assign out_res.initrom_enable   = out_initrom_r;
  assign out_res.bootram_writable = out_bootram_r;

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
module tb;
  import bmm_pkg::*;

  typedef struct packed {
    logic        cmd;
    logic [15:0] bus_addr;
    logic [7:0]  write_data;
  } access_t;

  typedef struct packed {
    region_t     region;
    logic [15:0] target;
    logic [7:0]  rd;
    logic        initrom;
    logic        bootram;
  } outcome_t;

  typedef struct packed {
    access_t  acc;
    logic     fixed;
    outcome_t want;
  } row_t;

  typedef struct packed {
    logic present;
    logic basic;
    int   count;
  } phase_t;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;
  localparam int HOLD_AFTER  = 600;

  localparam outcome_t NO_OUTCOME = '{RGN_UNHANDLED, 16'h0000, 8'h00, 1'b0, 1'b0};

  localparam row_t SCRIPT [25] = '{
    '{'{1'b0, ADDR_BOOT, 8'h00}, 1'b1, '{RGN_CTRL, ADDR_BOOT, 8'hfe, 1'b1, 1'b0}},
    '{'{1'b0, ADDR_MODE, 8'h00}, 1'b1, '{RGN_CTRL, ADDR_MODE, 8'h3e, 1'b1, 1'b0}},
    '{'{1'b0, 16'h0000, 8'h00}, 1'b1, '{RGN_MAIN, 16'h0000, 8'h00, 1'b1, 1'b0}},
    '{'{1'b1, 16'hffff, 8'hff}, 1'b1, '{RGN_UNHANDLED, 16'hffff, 8'h00, 1'b1, 1'b0}},
    '{'{1'b0, 16'hfc00, 8'h00}, 1'b1, '{RGN_UNHANDLED, 16'hfc00, 8'h00, 1'b1, 1'b0}},
    '{'{1'b1, ADDR_BOOT, 8'h00}, 1'b1, '{RGN_CTRL, ADDR_BOOT, 8'h00, 1'b1, 1'b0}},
    '{'{1'b1, ADDR_INITROM, 8'h02}, 1'b1, '{RGN_CTRL, ADDR_INITROM, 8'h00, 1'b0, 1'b0}},
    '{'{1'b0, ADDR_INITROM, 8'h00}, 1'b1, '{RGN_CTRL, ADDR_INITROM, 8'hff, 1'b0, 1'b0}},
    '{'{1'b1, ADDR_INITROM, 8'hfd}, 1'b1, '{RGN_CTRL, ADDR_INITROM, 8'h00, 1'b1, 1'b0}},
    '{'{1'b1, ADDR_SEG, 8'hff}, 1'b0, NO_OUTCOME},
    '{'{1'b0, 16'hfd8f, 8'h00}, 1'b0, NO_OUTCOME},
    '{'{1'b1, 16'hfd8f, 8'h3f}, 1'b0, NO_OUTCOME},
    '{'{1'b1, ADDR_MAP_BASE, 8'h25}, 1'b0, NO_OUTCOME},
    '{'{1'b1, 16'hfd81, 8'h12}, 1'b0, NO_OUTCOME},
    '{'{1'b1, 16'hfd82, 8'h07}, 1'b0, NO_OUTCOME},
    '{'{1'b0, 16'hfd8f, 8'h00}, 1'b0, NO_OUTCOME},
    '{'{1'b1, ADDR_MODE, 8'hc1}, 1'b0, NO_OUTCOME},
    '{'{1'b0, ADDR_MODE, 8'h00}, 1'b1, '{RGN_CTRL, ADDR_MODE, 8'hff, 1'b1, 1'b1}},
    '{'{1'b1, ADDR_WOFF, 8'hff}, 1'b0, NO_OUTCOME},
    '{'{1'b0, WIN_LO, 8'h00}, 1'b0, NO_OUTCOME},
    '{'{1'b0, WIN_HI, 8'h00}, 1'b0, NO_OUTCOME},
    '{'{1'b0, 16'h0123, 8'h00}, 1'b0, NO_OUTCOME},
    '{'{1'b1, 16'h0abc, 8'h5a}, 1'b0, NO_OUTCOME},
    '{'{1'b0, 16'h1fff, 8'h00}, 1'b0, NO_OUTCOME},
    '{'{1'b0, 16'hfbff, 8'h00}, 1'b0, NO_OUTCOME}
  };

  localparam phase_t PLAN [4] = '{
    '{1'b1, 1'b0, 700},
    '{1'b0, 1'b1, 300},
    '{1'b0, 1'b0, 300},
    '{1'b1, 1'b1, 700}
  };

  localparam logic [15:0] CORNERS [8] = '{
    16'h0000, 16'hffff, 16'hfbff, 16'hfc00, 16'h7bff, 16'h7c00, 16'h7fff, 16'h8000
  };

  logic clk = 1'b0;
  logic rst_n;

  bmm_in_if  in_bus();
  bmm_out_if out_res();
  bmm_cfg_if cfg_bus();

  banked_memory_mapper_top u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_res (out_res),
    .cfg_bus (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic               present;
  logic               basic;
  logic [ENTRY_W-1:0] pmap [MAP_DEPTH];
  logic [1:0]         seg;
  logic [7:0]         woff;
  logic               m_en;
  logic               w_en;
  logic               br_rw;
  logic               irom;

  outcome_t    decodes_due [$];
  int          errors;
  int          accepted;
  int          reg_hits;
  int          xlated;
  int          passthru;
  int unsigned cycle_count = 0;

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [MAP_IDX_W-1:0] map_slot(input logic [3:0] page);
    logic [1:0] s;
    s = (int'(seg) < SEGMENTS) ? seg : 2'd0;
    return {s, page};
  endfunction

  function automatic outcome_t decode_access(input access_t acc);
    outcome_t    o;
    logic [17:0] phys;
    logic [15:0] a;
    logic [15:0] win_addr;
    logic [7:0]  d;
    logic        hit;
    a = acc.bus_addr;
    d = acc.write_data;
    o.region = RGN_UNHANDLED;
    o.target = a;
    o.rd = 8'h00;
    if (present) begin
      if (a >= RESIDENT_BASE) begin
        hit = 1'b1;
        case (a)
          ADDR_BOOT: if (!acc.cmd) o.rd = basic ? STATUS_BASIC : BYTE_ONES;
          ADDR_INITROM: if (acc.cmd) irom = ~d[1]; else o.rd = BYTE_ONES;
          ADDR_SEG: if (acc.cmd) seg = d[1:0]; else o.rd = BYTE_ONES;
          ADDR_WOFF: if (acc.cmd) woff = d; else o.rd = BYTE_ONES;
          ADDR_MODE: begin
            if (acc.cmd) begin
              m_en = d[7];
              w_en = d[6];
              br_rw = d[0];
            end else begin
              o.rd = {m_en, w_en, 5'b11111, br_rw};
            end
          end
          default: begin
            if (a >= ADDR_MAP_BASE && a <= ADDR_MAP_BASE + 16'h000f) begin
              if (acc.cmd) pmap[map_slot(a[3:0])] = d[5:0];
              else o.rd = {2'b00, pmap[map_slot(a[3:0])]};
            end else begin
              hit = 1'b0;
            end
          end
        endcase
        if (hit) o.region = RGN_CTRL;
      end else begin
        win_addr = {woff, 8'h00} + a;
        if (w_en && a >= WIN_LO && a <= WIN_HI) phys = {2'b00, win_addr};
        else if (!m_en) phys = {2'b11, a};
        else phys = {pmap[map_slot(a[15:12])], a[11:0]};
        o.target = phys[15:0];
        case (phys[17:16])
          2'd0: o.region = RGN_EXT_RAM;
          2'd1: o.region = RGN_SUBSYS;
          2'd2: begin
            o.region = RGN_RESERVED;
            if (!acc.cmd) o.rd = BYTE_ONES;
          end
          default: o.region = RGN_MAIN;
        endcase
      end
    end
    o.initrom = irom;
    o.bootram = br_rw;
    return o;
  endfunction

  function automatic access_t random_access();
    access_t acc;
    int      pick;
    acc.cmd = 1'($urandom_range(0, 1));
    acc.write_data = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      if ($urandom_range(0, 3) == 0) acc.bus_addr = 16'($urandom_range(WIN_LO, WIN_HI));
      else acc.bus_addr = 16'($urandom_range(0, RESIDENT_BASE - 1));
    end else if (pick < 80) begin
      case ($urandom_range(0, 7))
        0, 1, 2: acc.bus_addr = 16'(ADDR_MAP_BASE + $urandom_range(0, PAGES_PER_SEGMENT - 1));
        3: acc.bus_addr = ADDR_SEG;
        4: acc.bus_addr = ADDR_WOFF;
        5: begin
          acc.bus_addr = ADDR_MODE;
          acc.write_data[7] = ($urandom_range(0, 3) != 0);
        end
        6: acc.bus_addr = ADDR_INITROM;
        default: acc.bus_addr = ADDR_BOOT;
      endcase
    end else if (pick < 95) begin
      acc.bus_addr = 16'($urandom_range(RESIDENT_BASE, 16'hffff));
    end else begin
      acc.bus_addr = CORNERS[3'($urandom_range(0, 7))];
      acc.write_data = $urandom_range(0, 1) ? 8'hff : 8'h00;
    end
    return acc;
  endfunction

  task automatic offer(input access_t acc, input logic fixed, input outcome_t want);
    outcome_t got;
    @(negedge clk);
    in_bus.valid <= 1'b1;
    in_bus.cmd <= acc.cmd;
    in_bus.bus_addr <= acc.bus_addr;
    in_bus.write_data <= acc.write_data;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    got = decode_access(acc);
    decodes_due.push_back(fixed ? want : got);
    accepted++;
  endtask

  task automatic idle(input int n);
    repeat (n) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
    end
  endtask

  task automatic settle();
    idle(1);
    while (decodes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_setting(input logic idx, input logic val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.addr <= idx;
    cfg_bus.data <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (idx == CFG_PRESENT) present = val;
    else basic = val;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic run_random(input int n);
    int left;
    int burst;
    int k;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      for (k = 0; k < burst && left > 0; k++) begin
        offer(random_access(), 1'b0, NO_OUTCOME);
        left--;
      end
      if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 6));
    end
  endtask

  always @(posedge clk) begin : check_results
    outcome_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (decodes_due.size() == 0) begin
        report($sformatf("item with nothing pending, target %04h", out_res.target_addr));
      end else begin
        want = decodes_due.pop_front();
        case (want.region)
          RGN_CTRL: reg_hits++;
          RGN_UNHANDLED: passthru++;
          default: xlated++;
        endcase
        if (out_res.region !== want.region)
          report($sformatf("region got %0d want %0d", out_res.region, want.region));
        if (out_res.target_addr !== want.target)
          report($sformatf("target_addr got %04h want %04h", out_res.target_addr, want.target));
        if (out_res.read_data !== want.rd)
          report($sformatf("read_data got %02h want %02h", out_res.read_data, want.rd));
        if (out_res.initrom_enable !== want.initrom)
          report($sformatf("initrom_enable got %b want %b", out_res.initrom_enable,
                           want.initrom));
        if (out_res.bootram_writable !== want.bootram)
          report($sformatf("bootram_writable got %b want %b", out_res.bootram_writable,
                           want.bootram));
      end
    end
  end

  initial begin : drain
    int  span;
    int  mode;
    logic held;
    held = 1'b0;
    out_res.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      // hold output ready low so the mapper backs up
      if (!held && accepted >= HOLD_AFTER) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_res.ready <= 1'b0;
        end
      end
      span = $urandom_range(8, 60);
      mode = $urandom_range(0, 2);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_res.ready <= 1'b1;
          1: out_res.ready <= 1'($urandom_range(0, 1));
          default: out_res.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("[banked_memory_mapper_top] ERROR");
    $finish;
  end

  initial begin : stimulus
    int i;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.cmd = 1'b0;
    in_bus.bus_addr = 16'h0000;
    in_bus.write_data = 8'h00;
    cfg_bus.valid = 1'b0;
    cfg_bus.addr = CFG_PRESENT;
    cfg_bus.data = 1'b0;
    errors = 0;
    accepted = 0;
    reg_hits = 0;
    xlated = 0;
    passthru = 0;
    present = 1'b1;
    basic = 1'b1;
    foreach (pmap[k]) pmap[k] = '0;
    seg = 2'd0;
    woff = 8'h00;
    m_en = 1'b0;
    w_en = 1'b0;
    br_rw = 1'b0;
    irom = 1'b1;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_setting(CFG_PRESENT, 1'b1);
    write_setting(CFG_BASIC, 1'b1);
    foreach (SCRIPT[r]) offer(SCRIPT[r].acc, SCRIPT[r].fixed, SCRIPT[r].want);

    for (i = 0; i < 4; i++) begin
      // drain before touching settings
      settle();
      write_setting(CFG_PRESENT, PLAN[i].present);
      write_setting(CFG_BASIC, PLAN[i].basic);
      run_random(PLAN[i].count);
    end
    settle();

    $display("checked %0d accesses: %0d control register, %0d translated, %0d unhandled",
             reg_hits + xlated + passthru, reg_hits, xlated, passthru);
    $display("mapper present and absent, both boot modes, one %0d-cycle output hold",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("[banked_memory_mapper_top] OK");
    end else begin
      $display("[banked_memory_mapper_top] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/bmm_pkg.sv
hdl/bmm_in_if.sv
hdl/bmm_out_if.sv
hdl/bmm_cfg_if.sv
hdl/bmm_map_ram.sv
hdl/bmm_decode.sv
hdl/banked_memory_mapper_top.sv
tb/sv/tb.sv
